// ===== hdl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet frame receiver package
// Shared sizes, register indexes, reset values and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

    // Payload buffer depth in bytes (1 to 64)
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS_ENABLE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ID         = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_HEADER_FIRST  = 8'd255;
    localparam logic [7:0] RST_HEADER_SECOND = 8'd170;
    localparam logic [7:0] RST_OWN_ID        = 8'd255;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_ACCEPTED  = 2'd0;
    localparam t_status ST_BAD_SUM   = 2'd1;
    localparam t_status ST_OTHER_DST = 2'd2;
    localparam t_status ST_TOO_LONG  = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/pfr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/packet_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Packet frame receiver
// Byte-stream deframer with additive payload checksum and replay buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one received byte per transaction on s_axis_tdata.
//   Master stream: result items; a good frame replays its payload bytes
//   from the buffer RAM after the checksum byte, a rejected or empty frame
//   gives a single status item. tlast marks the final item for that byte.
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data;
//   write only while the block is idle. o_cfg_ready is always high.
// Timing:
//   A status item sits in the output register the cycle after its byte is
//   taken. After a byte that causes no item, or a single item, the input is
//   ready again as long as the output register is free. Replay reads each
//   payload byte from the RAM, then loads it into the output register, one
//   byte at a time. The input is not ready during replay.
// Reset: synchronous, active low; control and config registers take their reset
//   values and the hunt starts at the first header byte. The payload RAM and the output data registers are not cleared.
// Stall: a pending item holds in the output register; the input is ready
//   only while that register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_frame_receiver_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Slave stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    // Master stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [1:0] status, [9:2] packet_type, [17:10] payload_byte, [23:18] byte_index
    output logic [23:0]                         m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] has_payload
    output logic                                m_axis_tlast,
    // Config write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data
);

    localparam int AW = pfr_pkg::ADDR_W;

    // Phase codes
    localparam logic [2:0] PH_HEAD1 = 3'd0;
    localparam logic [2:0] PH_HEAD2 = 3'd1;
    localparam logic [2:0] PH_DEST  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    // Config registers
    logic [7:0] r_header_first;
    logic [7:0] r_header_second;
    logic       r_address_enable;
    logic [7:0] r_own_id;

    // Frame state
    logic [2:0] r_phase,     n_phase;
    logic [7:0] r_dest,      n_dest;
    logic [7:0] r_type,      n_type;
    logic [6:0] r_frame_len, n_frame_len;
    logic [6:0] r_count,     n_count;
    logic [7:0] r_sum,       n_sum;

    // Replay state
    logic          r_rep_active, n_rep_active;
    logic          r_rep_rd,     n_rep_rd;
    logic [AW-1:0] r_rep_idx,    n_rep_idx;

    // Output register
    logic                  r_out_valid, n_out_valid;
    pfr_pkg::t_status      r_out_status;
    logic [7:0]            r_out_type;
    logic [7:0]            r_out_pay;
    logic [5:0]            r_out_idx;
    logic                  r_out_has;
    logic                  r_out_last;

    // Result load request
    logic                  res_load;
    pfr_pkg::t_status      res_status;
    logic [7:0]            res_pay;
    logic [5:0]            res_idx;
    logic                  res_has;
    logic                  res_last;

    // RAM ports
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_rd_en;
    logic [7:0]    ram_rd_data;

    logic       in_fire;
    logic       out_free;
    logic [6:0] count_inc;
    logic [7:0] sum_inc;
    logic       rep_last;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_rep_active && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign count_inc = r_count + 7'd1;
    assign sum_inc   = r_sum + s_axis_tdata;
    assign rep_last  = ((7'(r_rep_idx) + 7'd1) == r_frame_len);

    assign ram_wr_addr = r_count[AW-1:0];
    assign ram_rd_en   = r_rep_active && !r_rep_rd;

    // Payload buffer
    pfr_ram #(
        .WIDTH (8),
        .DEPTH (pfr_pkg::BUFFER_DEPTH)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rep_idx),
        .o_rd_data (ram_rd_data)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first   <= pfr_pkg::RST_HEADER_FIRST;
            r_header_second  <= pfr_pkg::RST_HEADER_SECOND;
            r_address_enable <= 1'b0;
            r_own_id         <= pfr_pkg::RST_OWN_ID;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pfr_pkg::CFG_HEADER_FIRST:   r_header_first   <= i_cfg_data;
                pfr_pkg::CFG_HEADER_SECOND:  r_header_second  <= i_cfg_data;
                pfr_pkg::CFG_ADDRESS_ENABLE: r_address_enable <= i_cfg_data[0];
                pfr_pkg::CFG_OWN_ID:         r_own_id         <= i_cfg_data;
            endcase
        end
    end

    // Parse bytes and sequence the replay
    always_comb begin
        n_phase      = r_phase;
        n_dest       = r_dest;
        n_type       = r_type;
        n_frame_len  = r_frame_len;
        n_count      = r_count;
        n_sum        = r_sum;
        n_rep_active = r_rep_active;
        n_rep_rd     = r_rep_rd;
        n_rep_idx    = r_rep_idx;
        ram_wr_en    = 1'b0;
        res_load     = 1'b0;
        res_status   = pfr_pkg::ST_ACCEPTED;
        res_pay      = 8'd0;
        res_idx      = 6'd0;
        res_has      = 1'b0;
        res_last     = 1'b1;

        if (in_fire) begin
            unique case (r_phase)
                PH_HEAD1: begin
                    if (s_axis_tdata == r_header_first) begin
                        n_phase = PH_HEAD2;
                    end
                end
                PH_HEAD2: begin
                    if (s_axis_tdata == r_header_second) begin
                        n_phase = r_address_enable ? PH_DEST : PH_TYPE;
                    end else begin
                        n_phase = PH_HEAD1;
                    end
                end
                PH_DEST: begin
                    n_dest  = s_axis_tdata;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = s_axis_tdata;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_sum   = 8'd0;
                    n_count = 7'd0;
                    if (s_axis_tdata > 8'(pfr_pkg::BUFFER_DEPTH)) begin
                        n_frame_len = 7'd0;
                        n_phase     = PH_HEAD1;
                        res_load    = 1'b1;
                        res_status  = pfr_pkg::ST_TOO_LONG;
                    end else begin
                        n_frame_len = s_axis_tdata[6:0];
                        n_phase     = (s_axis_tdata == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA: begin
                    ram_wr_en = 1'b1;
                    n_sum     = sum_inc;
                    n_count   = count_inc;
                    if (count_inc >= r_frame_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_HEAD1;
                    if (s_axis_tdata != r_sum) begin
                        res_load   = 1'b1;
                        res_status = pfr_pkg::ST_BAD_SUM;
                    end else if (r_address_enable && (r_dest != r_own_id)) begin
                        res_load   = 1'b1;
                        res_status = pfr_pkg::ST_OTHER_DST;
                    end else if (r_frame_len == 7'd0) begin
                        res_load   = 1'b1;
                        res_status = pfr_pkg::ST_ACCEPTED;
                    end else begin
                        n_rep_active = 1'b1;
                        n_rep_rd     = 1'b0;
                        n_rep_idx    = '0;
                    end
                end
                default: begin
                    n_phase = PH_HEAD1;
                end
            endcase
        end else if (r_rep_active) begin
            // Issue a read, then hand its data to the output register
            if (!r_rep_rd) begin
                n_rep_rd = 1'b1;
            end else if (out_free) begin
                res_load   = 1'b1;
                res_status = pfr_pkg::ST_ACCEPTED;
                res_pay    = ram_rd_data;
                res_idx    = 6'(r_rep_idx);
                res_has    = 1'b1;
                res_last   = rep_last;
                n_rep_rd   = 1'b0;
                if (rep_last) begin
                    n_rep_active = 1'b0;
                end else begin
                    n_rep_idx = r_rep_idx + AW'(1);
                end
            end
        end

        n_out_valid = res_load || (r_out_valid && !m_axis_tready);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEAD1;
            r_dest       <= 8'd0;
            r_type       <= 8'd0;
            r_frame_len  <= 7'd0;
            r_count      <= 7'd0;
            r_sum        <= 8'd0;
            r_rep_active <= 1'b0;
            r_rep_rd     <= 1'b0;
            r_rep_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_dest       <= n_dest;
            r_type       <= n_type;
            r_frame_len  <= n_frame_len;
            r_count      <= n_count;
            r_sum        <= n_sum;
            r_rep_active <= n_rep_active;
            r_rep_rd     <= n_rep_rd;
            r_rep_idx    <= n_rep_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // Output payload register; type is taken from the updated frame state
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_status <= res_status;
            r_out_type   <= n_type;
            r_out_pay    <= res_pay;
            r_out_idx    <= res_idx;
            r_out_has    <= res_has;
            r_out_last   <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_idx, r_out_pay, r_out_type, r_out_status};
    assign m_axis_tuser  = r_out_has;
    assign m_axis_tlast  = r_out_last;

    // Replay index stays inside the frame
    a_rep_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_active |-> (7'(r_rep_idx) < r_frame_len))
        else $error("replay index beyond frame length");

    // Stored frame length never exceeds the buffer
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_len <= 7'(pfr_pkg::BUFFER_DEPTH))
        else $error("frame length above buffer depth");

    // Payload items carry accepted status
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_has) |-> (r_out_status == pfr_pkg::ST_ACCEPTED))
        else $error("payload item with reject status");

    // A non-final item only appears while a replay is still running
    a_nonlast_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_rep_active)
        else $error("non-final item outside replay");

endmodule

`default_nettype wire

// ===== tb/sv/tb_packet_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet frame receiver testbench
// Streams received bytes into the deframer under random source and sink
// idling, and predicts every status and payload replay item in a scoreboard.
// The scoreboard checks each result against the oldest pending expectation.
// Register settings change between phases, including one change of address
// mode in the middle of a frame.
// ----------------------------------------------------------------------------

module tb_packet_frame_receiver_top;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;
    localparam int MAX_REPORTS = 10;

    // Hunt and frame field positions of the deframer
    typedef enum logic [2:0] {
        PH_HUNT_FIRST  = 3'd0,
        PH_HUNT_SECOND = 3'd1,
        PH_DEST        = 3'd2,
        PH_TYPE        = 3'd3,
        PH_LEN         = 3'd4,
        PH_DATA        = 3'd5,
        PH_SUM         = 3'd6
    } t_rx_phase;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_FOREIGN,
        FR_TOO_LONG,
        FR_BAD_HEADER,
        FR_NOISE
    } t_frame_kind;

    typedef struct packed {
        pfr_pkg::t_status status;
        logic [7:0]       ptype;
        logic [7:0]       payload;
        logic [5:0]       index;
        logic             has_payload;
        logic             last;
    } t_frame_result;

    // Deframer mirror and pending result store
    class frame_scoreboard;
        logic [7:0]    hdr_first;
        logic [7:0]    hdr_second;
        logic          addr_mode;
        logic [7:0]    node_id;
        t_rx_phase     phase;
        logic [7:0]    dest_id;
        logic [7:0]    frame_type;
        logic [6:0]    frame_len;
        logic [6:0]    rx_count;
        logic [7:0]    csum;
        logic [7:0]    payload_mem [pfr_pkg::BUFFER_DEPTH];
        t_frame_result expected_q [$];
        int            mismatch_count;
        int            checked_count;
        int            status_count [4];

        function new();
            hdr_first      = pfr_pkg::RST_HEADER_FIRST;
            hdr_second     = pfr_pkg::RST_HEADER_SECOND;
            addr_mode      = 1'b0;
            node_id        = pfr_pkg::RST_OWN_ID;
            phase          = PH_HUNT_FIRST;
            dest_id        = 8'h00;
            frame_type     = 8'h00;
            frame_len      = 7'd0;
            rx_count       = 7'd0;
            csum           = 8'h00;
            mismatch_count = 0;
            checked_count  = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function void write_reg(logic [pfr_pkg::CFG_INDEX_W-1:0] index, logic [7:0] data);
            case (index)
                pfr_pkg::CFG_HEADER_FIRST:   hdr_first  = data;
                pfr_pkg::CFG_HEADER_SECOND:  hdr_second = data;
                pfr_pkg::CFG_ADDRESS_ENABLE: addr_mode  = data[0];
                pfr_pkg::CFG_OWN_ID:         node_id    = data;
                default: ;
            endcase
        endfunction

        function void push_status(pfr_pkg::t_status st);
            expected_q.push_back('{status: st, ptype: frame_type, payload: 8'h00,
                                   index: 6'd0, has_payload: 1'b0, last: 1'b1});
        endfunction

        // Advance the frame hunt by one received byte
        function void note_byte(logic [7:0] rx);
            int k;
            case (phase)
                PH_HUNT_FIRST: begin
                    if (rx == hdr_first) phase = PH_HUNT_SECOND;
                end
                PH_HUNT_SECOND: begin
                    if (rx == hdr_second) phase = addr_mode ? PH_DEST : PH_TYPE;
                    else phase = PH_HUNT_FIRST;
                end
                PH_DEST: begin
                    dest_id = rx;
                    phase   = PH_TYPE;
                end
                PH_TYPE: begin
                    frame_type = rx;
                    phase      = PH_LEN;
                end
                PH_LEN: begin
                    csum     = 8'h00;
                    rx_count = 7'd0;
                    if (rx > pfr_pkg::BUFFER_DEPTH) begin
                        frame_len = 7'd0;
                        phase     = PH_HUNT_FIRST;
                        push_status(pfr_pkg::ST_TOO_LONG);
                    end else begin
                        frame_len = rx[6:0];
                        phase     = (rx == 8'h00) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA: begin
                    payload_mem[rx_count[pfr_pkg::ADDR_W-1:0]] = rx;
                    csum     = csum + rx;
                    rx_count = rx_count + 7'd1;
                    if (rx_count >= frame_len) phase = PH_SUM;
                end
                PH_SUM: begin
                    phase = PH_HUNT_FIRST;
                    if (rx != csum) begin
                        push_status(pfr_pkg::ST_BAD_SUM);
                    end else if (addr_mode && dest_id != node_id) begin
                        push_status(pfr_pkg::ST_OTHER_DST);
                    end else if (frame_len == 7'd0) begin
                        push_status(pfr_pkg::ST_ACCEPTED);
                    end else begin
                        // Replay the buffered payload, one item per byte
                        for (k = 0; k < int'(frame_len); k++) begin
                            expected_q.push_back('{status: pfr_pkg::ST_ACCEPTED,
                                                   ptype: frame_type,
                                                   payload: payload_mem[k[pfr_pkg::ADDR_W-1:0]],
                                                   index: k[5:0],
                                                   has_payload: 1'b1,
                                                   last: (k == int'(frame_len) - 1)});
                        end
                    end
                end
                default: phase = PH_HUNT_FIRST;
            endcase
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            checked_count++;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status=%0d type=%02h payload=%02h idx=%0d has=%0b last=%0b",
                             got.status, got.ptype, got.payload, got.index,
                             got.has_payload, got.last);
                return;
            end
            want = expected_q.pop_front();
            status_count[want.status]++;
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("mismatch exp: status=%0d type=%02h payload=%02h idx=%0d has=%0b last=%0b",
                             want.status, want.ptype, want.payload, want.index,
                             want.has_payload, want.last);
                    $display("         got: status=%0d type=%02h payload=%02h idx=%0d has=%0b last=%0b",
                             got.status, got.ptype, got.payload, got.index,
                             got.has_payload, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] status, [9:2] packet_type, [17:10] payload_byte, [23:18] byte_index
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;           // [0] has_payload
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [pfr_pkg::CFG_INDEX_W-1:0] i_cfg_index = pfr_pkg::CFG_HEADER_FIRST;
    logic [7:0]  i_cfg_data    = 8'h00;

    frame_scoreboard sb;
    logic [7:0]  directed_q [$];
    logic [7:0]  cfg_first  = pfr_pkg::RST_HEADER_FIRST;
    logic [7:0]  cfg_second = pfr_pkg::RST_HEADER_SECOND;
    logic        cfg_addr   = 1'b0;
    logic [7:0]  cfg_id     = pfr_pkg::RST_OWN_ID;
    bit          rst_done       = 1'b0;
    bit          hold_start     = 1'b0;
    logic        hold_off       = 1'b0;
    bit          sender_burst   = 1'b0;
    bit          receiver_burst = 1'b0;
    int          bytes_sent     = 0;
    int          cycle_count    = 0;

    packet_frame_receiver_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Abort a run that stops making progress
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
            $display("tb_packet_frame_receiver_top failed");
            $finish;
        end
    end

    function automatic int pick_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return FR_GOOD;
        if (r < 60) return FR_BAD_SUM;
        if (r < 70) return FR_FOREIGN;
        if (r < 78) return FR_TOO_LONG;
        if (r < 88) return FR_BAD_HEADER;
        return FR_NOISE;
    endfunction

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = pick_gap(sender_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        sb.note_byte(value);
        bytes_sent++;
    endtask

    // Drop valid, then wait out every pending result plus the idle latency
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] hf, input logic [7:0] hs,
                                input logic ae, input logic [7:0] id);
        logic [pfr_pkg::CFG_INDEX_W-1:0] regs [4];
        logic [7:0] vals [4];
        int r;
        regs = '{pfr_pkg::CFG_HEADER_FIRST, pfr_pkg::CFG_HEADER_SECOND,
                 pfr_pkg::CFG_ADDRESS_ENABLE, pfr_pkg::CFG_OWN_ID};
        vals = '{hf, hs, {7'd0, ae}, id};
        for (r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (o_cfg_ready !== 1'b1) @(posedge i_clk);
            sb.write_reg(regs[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
        cfg_first  = hf;
        cfg_second = hs;
        cfg_addr   = ae;
        cfg_id     = id;
    endtask

    // Build one frame of the given kind; without header it starts at the type byte
    task automatic send_frame(input t_frame_kind kind, input bit with_head, input int force_len);
        logic [7:0] len;
        logic [7:0] csum;
        logic [7:0] value;
        logic [7:0] dst;
        int n;
        if (kind == FR_NOISE) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (kind == FR_BAD_HEADER) begin
            send_byte(cfg_first);
            send_byte(cfg_second ^ 8'($urandom_range(1, 255)));
            return;
        end
        if (with_head) begin
            send_byte(cfg_first);
            send_byte(cfg_second);
            if (cfg_addr) begin
                case (kind)
                    FR_GOOD:    dst = cfg_id;
                    FR_FOREIGN: dst = cfg_id ^ 8'($urandom_range(1, 255));
                    default:    dst = 8'($urandom_range(0, 255));
                endcase
                send_byte(dst);
            end
        end
        send_byte(8'($urandom_range(0, 255)));
        if (kind == FR_TOO_LONG) begin
            len = (force_len >= 0) ? 8'(force_len) : 8'($urandom_range(65, 255));
            send_byte(len);
            return;
        end
        // Keep most payloads short, a few up to the buffer depth
        if (force_len >= 0) len = 8'(force_len);
        else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(9, pfr_pkg::BUFFER_DEPTH));
        else len = 8'($urandom_range(0, 8));
        send_byte(len);
        csum = 8'h00;
        repeat (len) begin
            value = 8'($urandom_range(0, 255));
            csum  = csum + value;
            send_byte(value);
        end
        if (kind == FR_BAD_SUM) csum = csum + 8'($urandom_range(1, 255));
        send_byte(csum);
    endtask

    task automatic run_random(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count) send_frame(pick_kind(), 1'b1, -1);
    endtask

    // Long sink hold-off so the output fills and the input stalls
    initial begin
        wait (hold_start);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Sink side: accept results with random gaps and check each one
    initial begin
        t_frame_result got;
        int gap;
        wait (rst_done);
        forever begin
            gap = pick_gap(receiver_burst);
            if (gap > 0 || hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            got.status      = m_axis_tdata[1:0];
            got.ptype       = m_axis_tdata[9:2];
            got.payload     = m_axis_tdata[17:10];
            got.index       = m_axis_tdata[23:18];
            got.has_payload = m_axis_tuser;
            got.last        = m_axis_tlast;
            sb.check_result(got);
        end
    end

    initial begin
        sb = new();
        // Noise, bad second header, empty frame, oversize length,
        // checksum mismatch, then a two-byte frame whose sum wraps to zero
        directed_q = '{8'h00,
                       8'hFF, 8'hFF, 8'hAA,
                       8'hFF, 8'hAA, 8'h00, 8'h00, 8'h00,
                       8'hFF, 8'hAA, 8'hFF, 8'h41,
                       8'hFF, 8'hAA, 8'h12, 8'h01, 8'hFF, 8'h00,
                       8'hFF, 8'hAA, 8'h34, 8'h02, 8'hFF, 8'h01, 8'h00};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        foreach (directed_q[i]) send_byte(directed_q[i]);
        run_random(12);

        // Address mode with a zero first header; hold the sink off meanwhile
        wait_drained();
        write_config(8'h00, 8'hFF, 1'b1, 8'h00);
        hold_start = 1'b1;
        send_frame(FR_GOOD, 1'b1, pfr_pkg::BUFFER_DEPTH);
        run_random(14);

        // Random headers; pause the source mid-phase until all results are in
        wait_drained();
        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 8'hFF);
        send_frame(FR_FOREIGN, 1'b1, -1);
        run_random(8);
        wait_drained();
        run_random(8);

        // Leave a frame open past its destination, then leave address mode
        send_byte(cfg_first);
        send_byte(cfg_second);
        send_byte(cfg_id);
        wait_drained();
        write_config(8'h55, 8'h55, 1'b0, 8'($urandom_range(0, 255)));
        send_frame(FR_GOOD, 1'b0, 2);
        run_random(12);

        // Back-to-back traffic on both sides
        wait_drained();
        write_config(8'hFF, 8'h00, 1'b1, 8'($urandom_range(0, 255)));
        sender_burst   = 1'b1;
        receiver_burst = 1'b1;
        send_frame(FR_TOO_LONG, 1'b1, 255);
        run_random(12);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes across five register settings; %0d results checked, %0d mismatches.",
                 bytes_sent, sb.checked_count, sb.mismatch_count);
        $display("Statuses seen: accepted %0d, bad checksum %0d, other address %0d, too long %0d.",
                 sb.status_count[pfr_pkg::ST_ACCEPTED], sb.status_count[pfr_pkg::ST_BAD_SUM],
                 sb.status_count[pfr_pkg::ST_OTHER_DST], sb.status_count[pfr_pkg::ST_TOO_LONG]);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("tb_packet_frame_receiver_top passed");
        end else begin
            $display("tb_packet_frame_receiver_top failed");
        end
        $finish;
    end

endmodule
